// ===== hw/rtl/arx_counter_random_generator_macros.svh =====
// assertion macros for the arx counter random generator checker
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef ARX_COUNTER_RANDOM_GENERATOR_MACROS_SVH
`define ARX_COUNTER_RANDOM_GENERATOR_MACROS_SVH

// property checked on every clock edge outside reset
`define ARXCRG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent in one cycle, consequent from the next cycle on
`define ARXCRG_ASSERT_NEXT(name, ante, cons, msg) \
  `ARXCRG_ASSERT(name, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/arxcrg_pkg.sv =====
// shared types, constants and mixing functions for the arx counter random generator
// no dependencies
package arxcrg_pkg;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned LANES         = 8;
  localparam int unsigned SEEDS         = 4;
  localparam int unsigned HALF_STEPS    = 12;  // six rounds, two half rounds each
  localparam int unsigned IN_W          = 8;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned BLK_DEPTH_DEF = 4;
  localparam int unsigned REQ_DEPTH_DEF = 2;

  localparam logic [WORD_W-1:0] PI_LANE_A = 64'h243F_6A88_85A3_08D3;
  localparam logic [WORD_W-1:0] PI_LANE_B = 64'h1319_8A2E_0370_7344;
  localparam logic [WORD_W-1:0] CTR_INIT  = '1;

  // rotation amounts of the first and second half round
  localparam int unsigned ROT_A0 = 3;
  localparam int unsigned ROT_A1 = 12;
  localparam int unsigned ROT_A2 = 24;
  localparam int unsigned ROT_A3 = 48;
  localparam int unsigned ROT_B0 = 7;
  localparam int unsigned ROT_B1 = 17;
  localparam int unsigned ROT_B2 = 23;
  localparam int unsigned ROT_B3 = 51;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [LANES-1:0] lanes_t;
  typedef word_t [SEEDS-1:0] seeds_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_0 = 8'd0,
    REG_SEED_1 = 8'd1,
    REG_SEED_2 = 8'd2,
    REG_SEED_3 = 8'd3
  } cfg_reg_e;

  // finished block leaving the mixing pipeline
  typedef struct packed {
    logic   valid;
    lanes_t words;
  } blk_t;

  // rotation by a constant amount between 1 and 63
  function automatic word_t rotl64(word_t v, int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  function automatic lanes_t block_input(word_t ctr, seeds_t seeds);
    lanes_t b;
    b[0] = ctr;
    b[1] = '0;
    b[2] = PI_LANE_A;
    b[3] = PI_LANE_B;
    b[4] = seeds[0];
    b[5] = seeds[1];
    b[6] = seeds[2];
    b[7] = seeds[3];
    return b;
  endfunction

  // one half round: add then xor-rotate, or xor then add-rotate
  function automatic lanes_t mix_half(lanes_t m_in, logic second);
    lanes_t m;
    m = m_in;
    if (!second) begin
      m[0] = m[0] + m[1];  m[1] = m[1] ^ rotl64(m[0], ROT_A0);
      m[2] = m[2] + m[3];  m[3] = m[3] ^ rotl64(m[2], ROT_A1);
      m[4] = m[4] + m[5];  m[5] = m[5] ^ rotl64(m[4], ROT_A2);
      m[6] = m[6] + m[7];  m[7] = m[7] ^ rotl64(m[6], ROT_A3);
    end else begin
      m[5] = m[5] ^ m[0];  m[0] = m[0] + rotl64(m[5], ROT_B0);
      m[6] = m[6] ^ m[1];  m[1] = m[1] + rotl64(m[6], ROT_B1);
      m[7] = m[7] ^ m[2];  m[2] = m[2] + rotl64(m[7], ROT_B2);
      m[4] = m[4] ^ m[3];  m[3] = m[3] + rotl64(m[4], ROT_B3);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/arx_counter_random_generator.sv =====
// counter-based 64-bit random word generator, top level; uses arxcrg_pkg and its submodules
// path: a request reaches the output through the request counter and the output register when
//   words are buffered; the first word after reset or a seed write also passes the 12 mixing
//   stages and the buffer write
// throughput: one word per cycle unless stalled, set by the output register; the 12-stage
//   mixing pipeline starts a block each cycle a slot is free, up to BlkDepth blocks ahead
// reset: asynchronous active low; seeds clear to zero, block counter to all ones, buffer empty
module arx_counter_random_generator #(
  parameter int unsigned BlkDepth = arxcrg_pkg::BLK_DEPTH_DEF,
  parameter int unsigned ReqDepth = arxcrg_pkg::REQ_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [arxcrg_pkg::IN_W-1:0]      s_axis_tdata_i,   // [0] take_word, [7:1] zero
  // word stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [arxcrg_pkg::WORD_W-1:0]    m_axis_tdata_o,   // [63:0] random_word
  // seed register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [arxcrg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [arxcrg_pkg::WORD_W-1:0]    cfg_data_i
);
  import arxcrg_pkg::*;

  localparam int unsigned SlotW = $clog2(BlkDepth + 1);

  // config state and block bookkeeping
  seeds_t           seeds_q;
  logic [SEEDS-1:0] seed_we;
  word_t            ctr_q, ctr_d;
  logic [SlotW-1:0] slots_q, slots_d;   // blocks issued and not yet fully read out
  logic             flush;
  logic             issue;
  logic             free;
  word_t            issue_ctr;

  // front to back request handshake
  logic             req_pending;
  logic             req_pop;
  blk_t             blk;

  // seed writes are always taken; a known index restarts the stream
  assign cfg_ready_o = 1'b1;

  always_comb begin
    seed_we = '0;
    flush   = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        REG_SEED_0, REG_SEED_1, REG_SEED_2, REG_SEED_3: begin
          flush                   = 1'b1;
          seed_we[cfg_index_i[1:0]] = 1'b1;
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeds_q <= '0;
    end else begin
      for (int k = 0; k < SEEDS; k++) begin
        if (seed_we[k]) begin
          seeds_q[k] <= cfg_data_i;
        end
      end
    end
  end

  // start a new block whenever a buffer slot is free and no flush is under way; counter pre-increments
  assign issue     = (slots_q != SlotW'(BlkDepth)) & ~flush;
  assign issue_ctr = ctr_q + WORD_W'(1);

  always_comb begin
    ctr_d   = issue ? issue_ctr : ctr_q;
    slots_d = slots_q + SlotW'(issue) - SlotW'(free);
    if (flush) begin
      ctr_d   = CTR_INIT;
      slots_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q   <= CTR_INIT;
      slots_q <= '0;
    end else begin
      ctr_q   <= ctr_d;
      slots_q <= slots_d;
    end
  end

  arxcrg_front #(
    .ReqDepth (ReqDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .req_pop_i       (req_pop),
    .req_pending_o   (req_pending)
  );

  arxcrg_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (flush),
    .issue_i (issue),
    .ctr_i   (issue_ctr),
    .seeds_i (seeds_q),
    .blk_o   (blk)
  );

  arxcrg_back #(
    .BlkDepth (BlkDepth)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .flush_i         (flush),
    .blk_i           (blk),
    .req_pending_i   (req_pending),
    .req_pop_o       (req_pop),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== hw/rtl/arxcrg_front.sv =====
// request front end: accepts input transfers and queues word requests
// depends on arxcrg_pkg
module arxcrg_front #(
  parameter int unsigned ReqDepth = arxcrg_pkg::REQ_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [arxcrg_pkg::IN_W-1:0] s_axis_tdata_i,   // [0] take_word
  input  logic                        req_pop_i,
  output logic                        req_pending_o
);
  import arxcrg_pkg::*;

  localparam int unsigned CntW = $clog2(ReqDepth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            take_word;

  assign take_word       = s_axis_tdata_i[0];
  assign s_axis_tready_o = (cnt_q != CntW'(ReqDepth));
  // a transfer with take_word low is consumed without a request
  assign push            = s_axis_tvalid_i & s_axis_tready_o & take_word;
  assign req_pending_o   = (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q + CntW'(push) - CntW'(req_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/arxcrg_mix.sv =====
// block mixing pipeline: one half round per stage, input block added back at the end
// depends on arxcrg_pkg
module arxcrg_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               flush_i,
  input  logic               issue_i,
  input  arxcrg_pkg::word_t  ctr_i,
  input  arxcrg_pkg::seeds_t seeds_i,
  output arxcrg_pkg::blk_t   blk_o
);
  import arxcrg_pkg::*;

  localparam int unsigned LAST = HALF_STEPS - 1;

  lanes_t stg_q [HALF_STEPS];
  word_t  ctr_q [HALF_STEPS];
  logic   vld_q [HALF_STEPS];
  lanes_t base;

  for (genvar s = 0; s < HALF_STEPS; s++) begin : g_stage
    lanes_t stg_in;
    word_t  ctr_in;
    logic   vld_in;

    if (s == 0) begin : g_first
      assign stg_in = block_input(ctr_i, seeds_i);
      assign ctr_in = ctr_i;
      assign vld_in = issue_i;
    end else begin : g_rest
      assign stg_in = stg_q[s-1];
      assign ctr_in = ctr_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in & ~flush_i;
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[s] <= mix_half(stg_in, 1'(s % 2));
      ctr_q[s] <= ctr_in;
    end
  end

  // seeds are only rewritten together with a flush, so the live values match
  always_comb begin
    base        = block_input(ctr_q[LAST], seeds_i);
    blk_o.valid = vld_q[LAST];
    for (int k = 0; k < LANES; k++) begin
      blk_o.words[k] = stg_q[LAST][k] + base[k];
    end
  end

endmodule

// ===== hw/rtl/arxcrg_back.sv =====
// word back end: block buffer, lane sequencing and the output register
// depends on arxcrg_pkg
module arxcrg_back #(
  parameter int unsigned BlkDepth = arxcrg_pkg::BLK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              flush_i,
  input  arxcrg_pkg::blk_t  blk_i,
  input  logic              req_pending_i,
  output logic              req_pop_o,
  output logic              free_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output arxcrg_pkg::word_t m_axis_tdata_o    // [63:0] random_word
);
  import arxcrg_pkg::*;

  localparam int unsigned PtrW  = $clog2(BlkDepth);
  localparam int unsigned CntW  = $clog2(BlkDepth + 1);
  localparam int unsigned LaneW = $clog2(LANES);

  lanes_t           mem_q [BlkDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [LaneW-1:0] lane_q, lane_d;
  logic             out_valid_q, out_valid_d;
  word_t            out_data_q;
  logic             wr, pop, last_lane;

  assign wr        = blk_i.valid & ~flush_i;
  assign pop       = req_pending_i & (cnt_q != '0) & (~out_valid_q | m_axis_tready_i);
  assign last_lane = (lane_q == LaneW'(LANES - 1));
  assign req_pop_o = pop;
  assign free_o    = pop & last_lane;

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    lane_d      = lane_q;
    cnt_d       = cnt_q + CntW'(wr) - CntW'(free_o);
    out_valid_d = pop | (out_valid_q & ~m_axis_tready_i);
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(BlkDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      lane_d = lane_q + LaneW'(1);
      if (last_lane) begin
        rd_ptr_d = (rd_ptr_q == PtrW'(BlkDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
    if (flush_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      lane_d   = '0;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      lane_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      lane_q      <= lane_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= blk_i.words;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_data_q <= mem_q[rd_ptr_q][lane_q];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== hw/rtl/arxcrg_chk.sv =====
// port-level checker for the arx counter random generator, bound to the top level
// depends on arxcrg_pkg and arx_counter_random_generator_macros.svh
`include "arx_counter_random_generator_macros.svh"

module arxcrg_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [arxcrg_pkg::IN_W-1:0]      s_axis_tdata_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [arxcrg_pkg::WORD_W-1:0]    m_axis_tdata_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [arxcrg_pkg::CFG_IDX_W-1:0] cfg_index_i
);

  logic seed_write;
  logic req_transfer;

  assign seed_write   = cfg_valid_i && cfg_ready_o && (cfg_index_i[7:2] == 6'd0);
  assign req_transfer = s_axis_tvalid_i && s_axis_tdata_i[0];

  // a stalled word stays put
  `ARXCRG_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "output word changed while stalled")

  // seed writes never back up
  `ARXCRG_ASSERT(a_cfg_ready, cfg_ready_o, "config port not ready")

  // the request queue only fills on a request transfer
  `ARXCRG_ASSERT_NEXT(a_in_ready_hold, s_axis_tready_o && !req_transfer, s_axis_tready_o, "input ready dropped without a request")

  // after a restart the buffer is empty, so the output does not raise a new word once the cleared count is registered
  `ARXCRG_ASSERT_NEXT(a_restart_empty, seed_write, ##1 !$rose(m_axis_tvalid_o), "word appeared right after a seed write")

endmodule

bind arx_counter_random_generator arxcrg_chk u_chk (.*);

// ===== dv/tb_arx_counter_random_generator.sv =====
// self-checking testbench for the arx counter random generator: request stream in,
// word stream out, seed writes between phases; a scoreboard class predicts every word
// depends on arxcrg_pkg and the arx_counter_random_generator rtl
`timescale 1ns / 1ps

module tb_arx_counter_random_generator;
  import arxcrg_pkg::*;

  localparam int unsigned CLK_HALF         = 4;
  localparam int unsigned RESULT_SETTLE    = 40;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned WORDS_PER_PHASE  = 100;
  localparam int unsigned NOISE_PCT        = 8;       // share of requests with take_word low
  localparam int unsigned HOLD_CYCLES      = 250;
  localparam int unsigned PRINT_CAP        = 50;

  // predicts the word stream: seeds, block counter and the eight-word buffer
  class arx_word_tracker;
    word_t       seed_words [SEEDS];
    word_t       block_ctr;
    word_t       block_words [LANES];
    int unsigned read_pos;
    word_t       pending_words [$];
    int unsigned errors;

    function new();
      foreach (seed_words[k]) seed_words[k] = '0;
      foreach (block_words[k]) block_words[k] = '0;
      block_ctr = CTR_INIT;
      read_pos  = LANES;
      errors    = 0;
    endfunction

    function word_t rotl(word_t v, int unsigned r);
      logic [2*WORD_W-1:0] twice;
      twice = {v, v};
      return twice[2*WORD_W-1-r -: WORD_W];
    endfunction

    // register write; unknown indexes leave everything as it was
    function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
      case (idx)
        REG_SEED_0: seed_words[0] = value;
        REG_SEED_1: seed_words[1] = value;
        REG_SEED_2: seed_words[2] = value;
        REG_SEED_3: seed_words[3] = value;
        default:    return;
      endcase
      block_ctr = CTR_INIT;
      read_pos  = LANES;
    endfunction

    function void take_request(bit take);
      word_t base [LANES];
      word_t m [LANES];
      if (!take) return;
      if (read_pos >= LANES) begin
        block_ctr = block_ctr + 1'b1;
        base[0] = block_ctr;
        base[1] = '0;
        base[2] = PI_LANE_A;
        base[3] = PI_LANE_B;
        for (int k = 0; k < SEEDS; k++) base[4+k] = seed_words[k];
        m = base;
        repeat (HALF_STEPS / 2) begin
          m[0] += m[1];  m[1] ^= rotl(m[0], ROT_A0);
          m[2] += m[3];  m[3] ^= rotl(m[2], ROT_A1);
          m[4] += m[5];  m[5] ^= rotl(m[4], ROT_A2);
          m[6] += m[7];  m[7] ^= rotl(m[6], ROT_A3);
          m[5] ^= m[0];  m[0] += rotl(m[5], ROT_B0);
          m[6] ^= m[1];  m[1] += rotl(m[6], ROT_B1);
          m[7] ^= m[2];  m[2] += rotl(m[7], ROT_B2);
          m[4] ^= m[3];  m[3] += rotl(m[4], ROT_B3);
        end
        for (int k = 0; k < LANES; k++) block_words[k] = m[k] + base[k];
        read_pos = 0;
      end
      pending_words.push_back(block_words[read_pos]);
      read_pos++;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(word_t got);
      word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("word %h with no request pending", got));
      end else begin
        want = pending_words.pop_front();
        if (got !== want) report($sformatf("random_word %h, predicted %h", got, want));
      end
    endtask

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;       // [0] take_word, rest zero
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [WORD_W-1:0]    m_axis_tdata;            // [63:0] random_word
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  // idling knobs, changed by the stimulus only just after a rising edge
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_left          = 0;
  int unsigned cycle_count        = 0;

  arx_word_tracker words = new();

  arx_counter_random_generator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // receiver side: a long hold-off when asked for, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // every transfer is seen here at the rising edge; requests are noted before words
  // are checked so a same-edge word still finds its prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) words.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) words.take_request(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) words.check_word(m_axis_tdata);
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[arx_counter_random_generator] ERROR");
      $finish;
    end
  end

  // one request transfer, with random idle cycles ahead of it
  task automatic send_request(input bit take);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-1){1'b0}}, take};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_requests();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // checked at falling edges, so the last transfer has already been noted
  task automatic wait_for_words();
    do @(negedge clk_i); while (words.pending() != 0);
  endtask

  // seeds are only written with the block idle: drained, then enough cycles for any block
  // already started to run out of the mixing pipeline
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
    end_requests();
    wait_for_words();
    repeat (RESULT_SETTLE) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // extremes often, random words otherwise
  function automatic word_t pick_seed();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
    @(posedge clk_i);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // new seeds, then a random request stream; ignored requests do not count as words
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit with_hold, input bit with_pause);
    int unsigned taken;
    bit          take;
    taken = 0;
    for (int k = 0; k < SEEDS; k++) begin
      if (k == 0 || $urandom_range(1)) write_reg(CFG_IDX_W'(k), pick_seed());
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, SEEDS)), pick_seed());
    end
    set_idling(idle_pct, stall_pct);
    // receiver shuts for a long stretch while the sender keeps offering requests
    if (with_hold) hold_left = HOLD_CYCLES;
    while (taken < WORDS_PER_PHASE) begin
      take = ($urandom_range(99) >= NOISE_PCT);
      send_request(take);
      if (take) taken++;
      // sender waits for every outstanding word halfway through
      if (with_pause && taken == WORDS_PER_PHASE / 2 && take) begin
        end_requests();
        wait_for_words();
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset seeds: dropped requests on an empty buffer, then past the first block
    send_request(1'b0);
    send_request(1'b0);
    repeat (4) send_request(1'b1);
    send_request(1'b0);
    repeat (6) send_request(1'b1);

    // all-ones seeds restart the stream at counter zero
    write_reg(REG_SEED_0, '1);
    write_reg(REG_SEED_1, '1);
    write_reg(REG_SEED_2, '1);
    write_reg(REG_SEED_3, '1);
    repeat (9) send_request(1'b1);

    // unknown index: no restart, stream carries on inside the current block
    write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, SEEDS)), {$urandom, $urandom});
    repeat (3) send_request(1'b1);

    run_phase(0, 0, 1'b1, 1'b0);
    run_phase(66, 0, 1'b0, 1'b0);
    run_phase(0, 66, 1'b0, 1'b1);
    run_phase(37, 37, 1'b0, 1'b0);

    end_requests();
    wait_for_words();
    repeat (RESULT_SETTLE) @(posedge clk_i);
    if (words.errors == 0) begin
      $display("[arx_counter_random_generator] OK");
    end else begin
      $display("[arx_counter_random_generator] ERROR");
    end
    $finish;
  end

endmodule
